@@ sv/rbf_pkg.sv @@
// shared types and constants of the ring buffer fifo
// used by rbf_front, rbf_back and ring_buffer_fifo; no dependencies
package rbf_pkg;

    localparam int DEPTH  = 64;
    localparam int ELEM_W = 8;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CAP_W  = $clog2(DEPTH + 1);
    localparam int REQ_W  = 2;

    // request codes on the input port
    localparam logic [REQ_W-1:0] REQ_PUT   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_GET   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DRAIN = 2'd2;

    // configuration register indexes
    localparam logic REG_CAPACITY = 1'b0;

    typedef enum logic [1:0] {
        CMD_PUT   = 2'd0,
        CMD_GET   = 2'd1,
        CMD_DRAIN = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd              cmd;
        logic [ELEM_W-1:0] data;
    } t_cmd_item;

    typedef struct packed {
        logic             clr;
        logic [CAP_W-1:0] cap;
    } t_cfg;

endpackage

@@ sv/rbf_front.sv @@
// front end: takes requests, classifies them and queues them for the back end
// depends on rbf_pkg
module rbf_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [rbf_pkg::REQ_W-1:0]        i_req_type,
    input  logic [rbf_pkg::ELEM_W-1:0]       i_put_data,
    output logic                             o_busy,
    output logic                             o_q_valid,
    output rbf_pkg::t_cmd_item               o_q_item,
    input  logic                             i_q_pop
);

    rbf_pkg::t_cmd_item r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_push;
    rbf_pkg::t_cmd_item w_item;

    always_comb begin
        w_item.data = '0;
        case (i_req_type)
            rbf_pkg::REQ_PUT: begin
                w_item.cmd  = rbf_pkg::CMD_PUT;
                w_item.data = i_put_data;
            end
            rbf_pkg::REQ_GET:   w_item.cmd = rbf_pkg::CMD_GET;
            rbf_pkg::REQ_DRAIN: w_item.cmd = rbf_pkg::CMD_DRAIN;
            default:            w_item.cmd = rbf_pkg::CMD_NOP;
        endcase
    end

    assign o_busy    = (r_cnt == 2'd2);
    assign w_push    = i_start && !o_busy;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
            case ({w_push, i_q_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_item;
        end
    end

endmodule

@@ sv/rbf_back.sv @@
// back end: ring storage, read/write indexes and result generation
// depends on rbf_pkg
module rbf_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  rbf_pkg::t_cfg                    i_cfg,
    input  logic                             i_q_valid,
    input  rbf_pkg::t_cmd_item               i_q_item,
    output logic                             o_q_pop,
    output logic                             o_valid,
    output logic                             o_ok,
    output logic [rbf_pkg::ELEM_W-1:0]       o_out_data,
    output logic                             o_last,
    output logic [rbf_pkg::IDX_W-1:0]        o_free_count
);

    typedef enum logic [1:0] {
        S_RUN   = 2'b01,
        S_DRAIN = 2'b10
    } t_state;

    logic [rbf_pkg::ELEM_W-1:0] r_mem [rbf_pkg::DEPTH];
    logic [rbf_pkg::ELEM_W-1:0] r_mem_q;

    t_state                    r_state, n_state;
    logic [rbf_pkg::IDX_W-1:0] r_wr_idx, n_wr_idx;
    logic [rbf_pkg::IDX_W-1:0] r_rd_idx, n_rd_idx;
    logic [rbf_pkg::IDX_W-1:0] r_count, n_count;
    logic                      r_valid, n_valid;
    logic                      r_ok, n_ok;
    logic                      r_last, n_last;
    logic                      r_use_mem, n_use_mem;
    logic [rbf_pkg::IDX_W-1:0] r_free;
    logic [rbf_pkg::IDX_W-1:0] w_cap_m1;
    logic                      w_we;

    function automatic logic [rbf_pkg::IDX_W-1:0] f_advance(
        input logic [rbf_pkg::IDX_W-1:0] idx,
        input logic [rbf_pkg::CAP_W-1:0] cap
    );
        logic [rbf_pkg::CAP_W-1:0] nxt;
        nxt = rbf_pkg::CAP_W'(idx) + rbf_pkg::CAP_W'(1);
        return (nxt >= cap) ? '0 : nxt[rbf_pkg::IDX_W-1:0];
    endfunction

    assign w_cap_m1 = rbf_pkg::IDX_W'(i_cfg.cap - rbf_pkg::CAP_W'(1));

    always_comb begin
        n_state   = r_state;
        n_wr_idx  = r_wr_idx;
        n_rd_idx  = r_rd_idx;
        n_count   = r_count;
        n_valid   = 1'b0;
        n_ok      = 1'b0;
        n_last    = 1'b1;
        n_use_mem = 1'b0;
        o_q_pop   = 1'b0;
        w_we      = 1'b0;
        case (r_state)
            S_RUN: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_valid = 1'b1;
                    case (i_q_item.cmd)
                        rbf_pkg::CMD_PUT: begin
                            if (r_count != w_cap_m1) begin
                                w_we     = 1'b1;
                                n_ok     = 1'b1;
                                n_wr_idx = f_advance(r_wr_idx, i_cfg.cap);
                                n_count  = r_count + rbf_pkg::IDX_W'(1);
                            end
                        end
                        rbf_pkg::CMD_GET: begin
                            if (r_count != '0) begin
                                n_ok      = 1'b1;
                                n_use_mem = 1'b1;
                                n_rd_idx  = f_advance(r_rd_idx, i_cfg.cap);
                                n_count   = r_count - rbf_pkg::IDX_W'(1);
                            end
                        end
                        rbf_pkg::CMD_DRAIN: begin
                            if (r_count != '0) begin
                                n_ok      = 1'b1;
                                n_use_mem = 1'b1;
                                n_rd_idx  = f_advance(r_rd_idx, i_cfg.cap);
                                n_count   = r_count - rbf_pkg::IDX_W'(1);
                                n_last    = (r_count == rbf_pkg::IDX_W'(1));
                                if (r_count != rbf_pkg::IDX_W'(1)) begin
                                    n_state = S_DRAIN;
                                end
                            end
                        end
                        default: begin
                            n_ok = 1'b0;
                        end
                    endcase
                end
            end
            S_DRAIN: begin
                // one stored element per cycle until the ring is empty
                n_valid   = 1'b1;
                n_ok      = 1'b1;
                n_use_mem = 1'b1;
                n_rd_idx  = f_advance(r_rd_idx, i_cfg.cap);
                n_count   = r_count - rbf_pkg::IDX_W'(1);
                n_last    = (r_count == rbf_pkg::IDX_W'(1));
                if (r_count == rbf_pkg::IDX_W'(1)) begin
                    n_state = S_RUN;
                end
            end
            default: begin
                n_state = S_RUN;
            end
        endcase
        if (i_cfg.clr) begin
            n_state  = S_RUN;
            n_wr_idx = '0;
            n_rd_idx = '0;
            n_count  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_RUN;
            r_wr_idx <= '0;
            r_rd_idx <= '0;
            r_count  <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_wr_idx <= n_wr_idx;
            r_rd_idx <= n_rd_idx;
            r_count  <= n_count;
            r_valid  <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ok      <= n_ok;
        r_last    <= n_last;
        r_use_mem <= n_use_mem;
        r_free    <= w_cap_m1 - n_count;
    end

    // storage: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_wr_idx] <= i_q_item.data;
        end
        r_mem_q <= r_mem[r_rd_idx];
    end

    assign o_valid      = r_valid;
    assign o_ok         = r_ok;
    assign o_last       = r_last;
    assign o_out_data   = r_use_mem ? r_mem_q : '0;
    assign o_free_count = r_free;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rbf_pkg::CAP_W'(r_count) < i_cfg.cap)
        else $error("occupancy exceeds usable capacity");

    a_idx_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_idx == r_rd_idx) == (r_count == '0))
        else $error("indexes disagree with occupancy");

    a_drain_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |-> (r_count != '0))
        else $error("drain running on an empty ring");

    a_mid_drain_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_last) |-> (r_ok && $past(n_state == S_DRAIN)))
        else $error("non-final result outside a drain");

endmodule

@@ sv/ring_buffer_fifo.sv @@
// top level of the ring buffer fifo: apb register port, front and back ends
// depends on rbf_pkg, rbf_front, rbf_back
//
// A request is taken when start is high and busy is low; busy rises only while
// a drain is being emitted and the two-entry request queue has filled. Put and
// get can be issued every cycle while busy is low; their single result appears
// on o_valid once the request has passed the front-end queue and the back-end
// result register. A drain emits one result per stored element, one per cycle,
// the last one marked by o_last; an empty ring gives one result with o_ok low.
// Results are shown for exactly one cycle and cannot be held off. Writing
// capacity_in_use (address 0) saturates the value to 2..64 and empties the
// ring; write it only while no request is outstanding.
module ring_buffer_fifo (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [rbf_pkg::REQ_W-1:0]        i_req_type,
    input  logic [rbf_pkg::ELEM_W-1:0]       i_put_data,
    output logic                             o_valid,
    output logic                             o_ok,
    output logic [rbf_pkg::ELEM_W-1:0]       o_out_data,
    output logic                             o_last,
    output logic [rbf_pkg::IDX_W-1:0]        o_free_count,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [2:0]                       paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    logic [rbf_pkg::CAP_W-1:0] r_cap;
    logic [rbf_pkg::CAP_W-1:0] w_cap_sat;
    logic                      w_cap_wr;
    logic                      w_q_valid;
    logic                      w_q_pop;
    rbf_pkg::t_cmd_item        w_q_item;
    rbf_pkg::t_cfg             w_cfg;

    assign pready   = 1'b1;
    assign w_cap_wr = psel && penable && pwrite && pready
                      && (paddr[2] == rbf_pkg::REG_CAPACITY);

    always_comb begin
        w_cap_sat = pwdata[rbf_pkg::CAP_W-1:0];
        if (w_cap_sat < rbf_pkg::CAP_W'(2)) begin
            w_cap_sat = rbf_pkg::CAP_W'(2);
        end else if (w_cap_sat > rbf_pkg::CAP_W'(rbf_pkg::DEPTH)) begin
            w_cap_sat = rbf_pkg::CAP_W'(rbf_pkg::DEPTH);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= rbf_pkg::CAP_W'(rbf_pkg::DEPTH);
        end else if (w_cap_wr) begin
            r_cap <= w_cap_sat;
        end
    end

    assign prdata = (paddr[2] == rbf_pkg::REG_CAPACITY) ? 32'(r_cap) : '0;

    assign w_cfg.clr = w_cap_wr;
    assign w_cfg.cap = r_cap;

    rbf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req_type (i_req_type),
        .i_put_data (i_put_data),
        .o_busy     (busy),
        .o_q_valid  (w_q_valid),
        .o_q_item   (w_q_item),
        .i_q_pop    (w_q_pop)
    );

    rbf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_q_valid    (w_q_valid),
        .i_q_item     (w_q_item),
        .o_q_pop      (w_q_pop),
        .o_valid      (o_valid),
        .o_ok         (o_ok),
        .o_out_data   (o_out_data),
        .o_last       (o_last),
        .o_free_count (o_free_count)
    );

endmodule

@@ sim/rbf_checker.sv @@
// scoreboard for ring_buffer_fifo: watches the request, result and apb channels,
// predicts each result and compares it with what the block returns
// depends on rbf_pkg
`timescale 1ns / 1ps

module rbf_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic                       i_busy,
    input  logic [rbf_pkg::REQ_W-1:0]  i_req_type,
    input  logic [rbf_pkg::ELEM_W-1:0] i_put_data,
    input  logic                       i_valid,
    input  logic                       i_ok,
    input  logic [rbf_pkg::ELEM_W-1:0] i_out_data,
    input  logic                       i_last,
    input  logic [rbf_pkg::IDX_W-1:0]  i_free_count,
    input  logic                       i_psel,
    input  logic                       i_penable,
    input  logic                       i_pwrite,
    input  logic                       i_pready,
    input  logic [2:0]                 i_paddr,
    input  logic [31:0]                i_pwdata,
    output int                         o_fail_count,
    output int                         o_results_due
);

    import rbf_pkg::*;

    typedef struct {
        logic              ok;
        logic [ELEM_W-1:0] data;
        logic              last;
        logic [IDX_W-1:0]  free;
    } t_fifo_result;

    t_fifo_result      results_due_q[$];
    logic [ELEM_W-1:0] ring_mem [DEPTH];
    logic [IDX_W-1:0]  wr_ptr;
    logic [IDX_W-1:0]  rd_ptr;
    logic [CAP_W-1:0]  slots_in_use;
    int                mismatches;

    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
        int n;
        n = int'(idx) + 1;
        if (n >= int'(slots_in_use) || n >= DEPTH) begin
            n = 0;
        end
        return IDX_W'(n);
    endfunction

    function automatic logic [IDX_W-1:0] free_slots();
        int n;
        if (wr_ptr == rd_ptr) begin
            n = int'(slots_in_use) - 1;
        end else if (wr_ptr < rd_ptr) begin
            n = int'(rd_ptr) - int'(wr_ptr) - 1;
        end else begin
            n = int'(slots_in_use) + int'(rd_ptr) - int'(wr_ptr) - 1;
        end
        return IDX_W'(n);
    endfunction

    task automatic queue_result(input logic ok, input logic [ELEM_W-1:0] data,
                                input logic last);
        t_fifo_result r;
        r.ok   = ok;
        r.data = data;
        r.last = last;
        r.free = free_slots();
        results_due_q.push_back(r);
    endtask

    // predicts every result caused by one accepted request
    task automatic predict_request(input t_cmd cmd, input logic [ELEM_W-1:0] data);
        logic [IDX_W-1:0]  nxt;
        logic [ELEM_W-1:0] v;
        int                k;
        k = 0;
        case (cmd)
            CMD_PUT: begin
                nxt = ring_next(wr_ptr);
                if (nxt != rd_ptr) begin
                    ring_mem[wr_ptr] = data;
                    wr_ptr = nxt;
                    queue_result(1'b1, '0, 1'b1);
                end else begin
                    queue_result(1'b0, '0, 1'b1);
                end
            end
            CMD_GET: begin
                if (wr_ptr != rd_ptr) begin
                    v = ring_mem[rd_ptr];
                    rd_ptr = ring_next(rd_ptr);
                    queue_result(1'b1, v, 1'b1);
                end else begin
                    queue_result(1'b0, '0, 1'b1);
                end
            end
            CMD_DRAIN: begin
                if (wr_ptr == rd_ptr) begin
                    queue_result(1'b0, '0, 1'b1);
                end
                while (wr_ptr != rd_ptr && k < DEPTH - 1) begin
                    v = ring_mem[rd_ptr];
                    rd_ptr = ring_next(rd_ptr);
                    queue_result(1'b1, v, wr_ptr == rd_ptr);
                    k++;
                end
            end
            default: begin
                queue_result(1'b0, '0, 1'b1);
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_fifo_result     want;
        logic [31:0]      cap_val;
        if (!i_rst_n) begin
            results_due_q.delete();
            wr_ptr       = '0;
            rd_ptr       = '0;
            slots_in_use = CAP_W'(DEPTH);
        end else begin
            // results first: nothing accepted at this edge can already be out
            if (i_valid) begin
                if (results_due_q.size() == 0) begin
                    $display("%0t: unexpected result: ok=%0b data=%02h last=%0b free=%0d",
                             $time, i_ok, i_out_data, i_last, i_free_count);
                    mismatches++;
                end else begin
                    want = results_due_q.pop_front();
                    if (want.ok !== i_ok || want.data !== i_out_data ||
                        want.last !== i_last || want.free !== i_free_count) begin
                        $display({"%0t: result mismatch: ",
                                  "expected ok=%0b data=%02h last=%0b free=%0d, ",
                                  "got ok=%0b data=%02h last=%0b free=%0d"},
                                 $time, want.ok, want.data, want.last, want.free,
                                 i_ok, i_out_data, i_last, i_free_count);
                        mismatches++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                predict_request(t_cmd'(i_req_type), i_put_data);
            end
            if (i_psel && i_penable && i_pwrite && i_pready &&
                (i_paddr >> 2) == 3'(REG_CAPACITY)) begin
                cap_val = {25'd0, i_pwdata[6:0]};
                if (cap_val < 2) begin
                    cap_val = 2;
                end
                if (cap_val > DEPTH) begin
                    cap_val = DEPTH;
                end
                slots_in_use = CAP_W'(cap_val);
                wr_ptr       = '0;
                rd_ptr       = '0;
            end
        end
        o_fail_count  <= mismatches;
        o_results_due <= results_due_q.size();
    end

endmodule

@@ sim/ring_buffer_fifo_tb.sv @@
// testbench top for ring_buffer_fifo: clock, reset, request and apb stimulus,
// watchdog and verdict; checking is done by rbf_checker
// depends on rbf_pkg, ring_buffer_fifo, rbf_checker
`timescale 1ns / 1ps

module ring_buffer_fifo_tb;

    import rbf_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int N_PHASES    = 7;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [REQ_W-1:0]  i_req_type;
    logic [ELEM_W-1:0] i_put_data;
    logic              o_valid;
    logic              o_ok;
    logic [ELEM_W-1:0] o_out_data;
    logic              o_last;
    logic [IDX_W-1:0]  o_free_count;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [2:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    int fail_count;
    int results_due;
    int stall_cycles;
    bit gaps_on;

    ring_buffer_fifo dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_req_type   (i_req_type),
        .i_put_data   (i_put_data),
        .o_valid      (o_valid),
        .o_ok         (o_ok),
        .o_out_data   (o_out_data),
        .o_last       (o_last),
        .o_free_count (o_free_count),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    rbf_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_req_type    (i_req_type),
        .i_put_data    (i_put_data),
        .i_valid       (o_valid),
        .i_ok          (o_ok),
        .i_out_data    (o_out_data),
        .i_last        (o_last),
        .i_free_count  (o_free_count),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_pready      (pready),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .o_fail_count  (fail_count),
        .o_results_due (results_due)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // ends the run if nothing moves on any channel for too long
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || (psel && penable)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // issues one request and returns at the edge that accepts it
    task automatic send_req(input t_cmd cmd, input logic [ELEM_W-1:0] data);
        while (gaps_on && $urandom_range(0, 99) < 28) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start      <= 1'b1;
        i_req_type <= cmd;
        i_put_data <= data;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
    endtask

    // stops issuing and waits until every predicted result is out
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge i_clk);
        while (results_due != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_reqs(input int n_reqs, input int put_pct, input int get_pct,
                               input int drain_pct);
        int r;
        for (int i = 0; i < n_reqs; i++) begin
            r = $urandom_range(0, 99);
            if (r < put_pct) begin
                send_req(CMD_PUT, ELEM_W'($urandom));
            end else if (r < put_pct + get_pct) begin
                send_req(CMD_GET, ELEM_W'($urandom));
            end else if (r < put_pct + get_pct + drain_pct) begin
                send_req(CMD_DRAIN, ELEM_W'($urandom));
            end else begin
                send_req(CMD_NOP, ELEM_W'($urandom));
            end
        end
    endtask

    initial begin
        logic [31:0] cap_writes [N_PHASES];
        int          put_pct;

        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_req_type = CMD_PUT;
        i_put_data = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        gaps_on    = 1'b1;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // full capacity after reset: empty get and drain, reserved code, extremes
        send_req(CMD_GET, 8'h00);
        send_req(CMD_DRAIN, 8'h00);
        send_req(CMD_NOP, 8'hFF);
        send_req(CMD_PUT, 8'h00);
        send_req(CMD_PUT, 8'hFF);
        send_req(CMD_PUT, 8'h5A);
        send_req(CMD_GET, 8'h00);
        send_req(CMD_DRAIN, 8'h00);
        send_req(CMD_DRAIN, 8'h00);
        wait_idle();

        // write to a nonexistent register must be ignored
        apb_write(3'd4, 32'd5);
        // zero saturates to the smallest ring: room for one element
        apb_write(3'd0, 32'd0);
        send_req(CMD_PUT, 8'h81);
        send_req(CMD_PUT, 8'h7E);
        send_req(CMD_GET, 8'h00);
        send_req(CMD_GET, 8'h00);
        send_req(CMD_PUT, 8'h3C);
        send_req(CMD_DRAIN, 8'h00);
        send_req(CMD_PUT, 8'h55);
        send_req(CMD_NOP, 8'hAA);
        send_req(CMD_GET, 8'h00);
        wait_idle();

        // capacities: masked to 7 bits, then saturated to 2..64
        cap_writes[0] = 32'h0000_007F;
        cap_writes[1] = 32'h0000_0001;
        cap_writes[2] = 32'h0000_0085;
        cap_writes[3] = 32'd17;
        cap_writes[4] = 32'hFFFF_FFFF;
        cap_writes[5] = 32'd3;
        cap_writes[6] = 32'($urandom_range(2, 64));
        for (int p = 0; p < N_PHASES; p++) begin
            apb_write(3'd0, cap_writes[p]);
            if (p == 4) begin
                // back-to-back requests, mostly puts, at full size until the ring fills, no gaps
                gaps_on = 1'b0;
                random_reqs(100, 92, 6, 1);
                gaps_on = 1'b1;
            end else begin
                put_pct = $urandom_range(35, 65);
                random_reqs(30, put_pct, 92 - put_pct, 6);
            end
            wait_idle();
        end

        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
sv/rbf_pkg.sv
sv/rbf_front.sv
sv/rbf_back.sv
sv/ring_buffer_fifo.sv
sim/rbf_checker.sv
sim/ring_buffer_fifo_tb.sv
